// ===== hdl/s224_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-224 package
// Beat types, initial hash values and round constants.
// ----------------------------------------------------------------------------
package s224_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam int unsigned DigestWords = 7;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'hc1059ed8;
      3'd1: v = 32'h367cd507;
      3'd2: v = 32'h3070dd17;
      3'd3: v = 32'hf70e5939;
      3'd4: v = 32'hffc00b31;
      3'd5: v = 32'h68581511;
      3'd6: v = 32'h64f98fa7;
      default: v = 32'hbefa4fa4;
    endcase
    return v;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== hdl/sha224_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-224 byte stream hasher
// Absorbs message bytes one per beat; a finish beat pads, compresses and
// returns the seven digest words.
// ----------------------------------------------------------------------------
// An absorb beat writes its byte into the block memory, and the 64th byte of
// a block also starts a compression: the 64 block bytes and the eight
// chaining words are streamed out of their memories, 64 rounds run at one per
// cycle, then the working variables are folded into the chaining
// memory (a read and a write per word). A finish beat writes the padding one
// byte per cycle, from the first free byte to the end of the block; when more
// than 55 bytes are held it runs a compression and clears bytes 0 to 55. It
// then writes the 8 length bytes, runs the last compression and returns the
// seven digest words, each held until the receiver takes it. The next beat is
// taken only when the block is back in its idle state. Both the block bytes
// and the chaining words sit in single-port synchronous memories whose read
// data arrives in the next cycle; the chain memory is loaded with the initial
// values after reset and after every digest, during which no beat is taken.
module sha224_byte_stream_hasher (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  s224_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output s224_pkg::out_beat_t  out_data
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PAD, S_ZERO, S_LEN, S_LOAD, S_ROUND, S_FOLD, S_EMIT_RD, S_EMIT,
    S_WAIT
  } state_t;

  state_t      state;
  logic [7:0]  blk_mem [64];
  logic [31:0] chain_mem [8];
  logic [7:0]  blk_rd;
  logic [31:0] chain_rd;

  logic [5:0]  byte_count;
  logic [63:0] bit_length;
  logic [6:0]  step;
  logic        final_blk;
  logic        two_blk;
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;

  // memory access control (combinational)
  logic        blk_we;
  logic [5:0]  blk_addr;
  logic [7:0]  blk_wd;
  logic        ch_we;
  logic [2:0]  ch_addr;
  logic [31:0] ch_wd;
  logic [63:0] len_shift;
  logic [31:0] fold_var;

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_addr] <= blk_wd;
    blk_rd <= blk_mem[blk_addr];
    if (ch_we) chain_mem[ch_addr] <= ch_wd;
    chain_rd <= chain_mem[ch_addr];
  end

  // round datapath
  logic [31:0] s0, s1, w_new, big0, big1, ch_f, maj_f, t1, t2, wr;
  always_comb begin
    s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    ch_f = (e & f) ^ (~e & g);
    big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    maj_f = (a & b) ^ (a & c) ^ (b & c);
    wr = w[0];
    t1 = h + big1 + ch_f + s224_pkg::RoundK[step[5:0]] + wr;
    t2 = big0 + maj_f;
  end

  logic in_take;
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // working variable folded into chain word step/2
  always_comb begin
    unique case (step[3:1])
      3'd0: fold_var = a;
      3'd1: fold_var = b;
      3'd2: fold_var = c;
      3'd3: fold_var = d;
      3'd4: fold_var = e;
      3'd5: fold_var = f;
      3'd6: fold_var = g;
      default: fold_var = h;
    endcase
  end

  always_comb begin
    blk_we = 1'b0;
    blk_addr = byte_count;
    blk_wd = in_data.data_byte;
    ch_we = 1'b0;
    ch_addr = step[2:0];
    ch_wd = s224_pkg::init_hash(step[2:0]);
    len_shift = bit_length >> {3'd7 - step[2:0], 3'b000};
    unique case (state)
      S_INIT: ch_we = 1'b1;
      S_IDLE: begin
        blk_we = in_take && (in_data.operation == s224_pkg::OP_ABSORB);
      end
      S_PAD: begin
        // 0x80 at the first free byte, zeros up to the end of the block
        blk_we = 1'b1;
        blk_addr = step[5:0];
        blk_wd = (step[5:0] == byte_count) ? 8'h80 : 8'h00;
      end
      S_ZERO: begin
        blk_we = 1'b1;
        blk_addr = step[5:0];
        blk_wd = 8'h00;
      end
      S_LEN: begin
        blk_we = 1'b1;
        blk_addr = {3'b111, step[2:0]};
        blk_wd = len_shift[7:0];
      end
      S_LOAD: blk_addr = step[5:0];
      S_FOLD: begin
        // read on even steps, write the sum on odd steps
        ch_we = step[0];
        ch_addr = step[3:1];
        ch_wd = chain_rd + fold_var;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      step <= '0;
      byte_count <= '0;
      bit_length <= '0;
      out_valid <= 1'b0;
      out_data <= '0;
      final_blk <= 1'b0;
      two_blk <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          step <= step + 7'd1;
          if (step[2:0] == 3'd7) begin
            step <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            if (in_data.operation == s224_pkg::OP_ABSORB) begin
              bit_length <= bit_length + 64'd8;
              byte_count <= byte_count + 6'd1;
              if (byte_count == 6'd63) begin
                final_blk <= 1'b0;
                step <= '0;
                state <= S_LOAD;
              end
            end else begin
              two_blk <= (byte_count > 6'd55);
              final_blk <= 1'b1;
              step <= {1'b0, byte_count};
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          step <= step + 7'd1;
          if (step[5:0] == 6'd63) begin
            step <= '0;
            state <= two_blk ? S_LOAD : S_LEN;
          end
        end
        S_ZERO: begin
          step <= step + 7'd1;
          if (step[5:0] == 6'd55) begin
            step <= '0;
            state <= S_LEN;
          end
        end
        S_LEN: begin
          step <= step + 7'd1;
          if (step[2:0] == 3'd7) begin
            step <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          // reads arrive in the next cycle; shift bytes into the word window
          if (step != 7'd0) begin
            for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i + 1][31:24]};
            w[15] <= {w[15][23:0], blk_rd};
          end
          if (step != 7'd0 && step <= 7'd8) begin
            a <= b;
            b <= c;
            c <= d;
            d <= e;
            e <= f;
            f <= g;
            g <= h;
            h <= chain_rd;
          end
          step <= step + 7'd1;
          if (step == 7'd64) begin
            step <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          h <= g;
          g <= f;
          f <= e;
          e <= d + t1;
          d <= c;
          c <= b;
          b <= a;
          a <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          step <= step + 7'd1;
          if (step[5:0] == 6'd63) begin
            step <= '0;
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          step <= step + 7'd1;
          if (step[3:0] == 4'd15) begin
            step <= '0;
            priority if (!final_blk) begin
              state <= S_IDLE;
            end else if (two_blk) begin
              two_blk <= 1'b0;
              state <= S_ZERO;
            end else begin
              state <= S_EMIT_RD;
            end
          end
        end
        S_EMIT_RD: state <= S_EMIT;
        S_EMIT: begin
          out_valid <= 1'b1;
          out_data.digest_word <= chain_rd;
          out_data.word_index <= step[2:0];
          out_data.last_word <= (step[2:0] == 3'(s224_pkg::DigestWords - 1));
          state <= S_WAIT;
        end
        S_WAIT: begin
          // hold the beat until the receiver takes it
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (step[2:0] == 3'(s224_pkg::DigestWords - 1)) begin
              step <= '0;
              byte_count <= '0;
              bit_length <= '0;
              final_blk <= 1'b0;
              state <= S_INIT;
            end else begin
              step <= step + 7'd1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== bench/tb_sha224_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-224 byte stream hasher testbench
// Feeds directed and random byte messages with finish beats, predicts every
// digest word with a local SHA-224 model and compares each output beat.
// ----------------------------------------------------------------------------
module tb_sha224_byte_stream_hasher;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  s224_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  s224_pkg::out_beat_t out_data;

  sha224_byte_stream_hasher u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  localparam int unsigned CycleLimit = 2_000_000;

  // predictor state
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] msg_bits;

  s224_pkg::out_beat_t digest_q [$];
  int unsigned errors = 0;
  int unsigned words_seen = 0;
  int unsigned msgs_done = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + s224_pkg::RoundK[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  function automatic void new_message();
    for (int i = 0; i < 8; i++) chain[i] = s224_pkg::init_hash(3'(i));
    fill = '0;
    msg_bits = '0;
  endfunction

  task automatic predict(input s224_pkg::in_beat_t b);
    s224_pkg::out_beat_t o;
    if (b.operation == s224_pkg::OP_ABSORB) begin
      blk[fill] = b.data_byte;
      msg_bits += 64'd8;
      if (fill == 6'd63) compress();
      fill++;
    end else begin
      blk[fill] = 8'h80;
      for (int i = fill + 1; i < 64; i++) blk[i] = '0;
      if (fill > 6'd55) begin
        compress();
        for (int i = 0; i < 64; i++) blk[i] = '0;
      end
      for (int i = 0; i < 8; i++) blk[63-i] = msg_bits[8*i +: 8];
      compress();
      for (int i = 0; i < s224_pkg::DigestWords; i++) begin
        o.digest_word = chain[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == s224_pkg::DigestWords - 1);
        digest_q.push_back(o);
      end
      new_message();
    end
  endtask

  // a known-answer check for the empty message, typed in from the standard
  localparam logic [31:0] EmptyDigest [7] = '{
    32'hd14a028c, 32'h2a3a2bc9, 32'h476102bb, 32'h288234c4,
    32'h15a2b01f, 32'h828ea62a, 32'hc5b3e42f
  };

  // leaves valid high after the beat; the caller drops it when going quiet
  task automatic send(input logic op, input logic [7:0] d);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, data_byte: d};
    do @(posedge clk); while (in_stall);
    predict('{operation: op, data_byte: d});
    items_sent++;
  endtask

  task automatic send_msg(input int len, input logic [7:0] pat, input bit rnd);
    for (int i = 0; i < len; i++)
      send(s224_pkg::OP_ABSORB, rnd ? 8'($urandom) : pat);
    send(s224_pkg::OP_FINISH, 8'($urandom));
  endtask

  // output side: stall, check
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $error("digest word with nothing expected: %h", out_data.digest_word);
          errors++;
        end else begin
          s224_pkg::out_beat_t e;
          e = digest_q.pop_front();
          if (out_data.digest_word !== e.digest_word) begin
            $error("digest_word expected %h actual %h", e.digest_word, out_data.digest_word);
            errors++;
          end
          if (out_data.word_index !== e.word_index) begin
            $error("word_index expected %0d actual %0d", e.word_index, out_data.word_index);
            errors++;
          end
          if (out_data.last_word !== e.last_word) begin
            $error("last_word expected %0d actual %0d", e.last_word, out_data.last_word);
            errors++;
          end
          words_seen++;
          if (e.last_word) msgs_done++;
        end
      end
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // directed rows: message length, fill byte (or random), finish
  typedef struct {
    int         len;
    logic [7:0] pat;
    bit         rnd;
  } msg_row_t;

  localparam int NumRows = 6;
  msg_row_t rows [NumRows] = '{
    '{0, 8'h00, 1'b0},   // empty message, known answer
    '{1, 8'hff, 1'b0},
    '{55, 8'h5a, 1'b0},  // length still fits in one block
    '{56, 8'ha5, 1'b0},  // padding spills into a second block
    '{64, 8'h00, 1'b0},  // exactly one full block
    '{3, 8'h00, 1'b1}
  };

  initial begin
    new_message();
    for (int i = 0; i < 64; i++) blk[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty message checked against the published digest too
    send_msg(0, 8'h00, 1'b0);
    for (int i = 0; i < s224_pkg::DigestWords; i++)
      if (digest_q[i].digest_word !== EmptyDigest[i]) begin
        $error("digest_word expected %h actual %h", EmptyDigest[i], digest_q[i].digest_word);
        errors++;
      end
    for (int r = 1; r < NumRows; r++)
      send_msg(rows[r].len, rows[r].pat, rows[r].rnd);

    // hold off until every digest word is back
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      // short random messages
      for (int m = 0; m < 3; m++)
        send_msg($urandom_range(0, 5), 8'h00, 1'b1);
    end
    // a stray finish right after a finish
    send(s224_pkg::OP_FINISH, 8'h00);

    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d beats in %0d messages, %0d digest words checked",
             items_sent, msgs_done, words_seen);
    $display("covered empty, one-block, two-block padding and random stall patterns");
    if (errors == 0 && digest_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/s224_pkg.sv
hdl/sha224_byte_stream_hasher.sv
bench/tb_sha224_byte_stream_hasher.sv
